### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/lacb_pkg.sv
`default_nettype none
package lacb_pkg;
	localparam int COORD_WIDTH    = 32;
	localparam int UNIT_FRAC_BITS = 14;
	localparam int UNIT_WIDTH     = UNIT_FRAC_BITS + 2;
	localparam int PS_BITS        = 30;
	localparam int PS_LAT         = 4;
	localparam int NORM_LAT       = PS_BITS + UNIT_FRAC_BITS + 6;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [UNIT_WIDTH-1:0]  unit_t;
	typedef logic [PS_BITS-1:0]            pmag_t;

	typedef struct packed {
		coord_t eye_x;
		coord_t eye_y;
		coord_t eye_z;
		coord_t target_x;
		coord_t target_y;
		coord_t target_z;
		coord_t up_hint_x;
		coord_t up_hint_y;
		coord_t up_hint_z;
	} cmd_t;

	typedef struct packed {
		unit_t right_x;
		unit_t right_y;
		unit_t right_z;
		unit_t true_up_x;
		unit_t true_up_y;
		unit_t true_up_z;
		unit_t forward_x;
		unit_t forward_y;
		unit_t forward_z;
		logic  degenerate;
	} basis_t;
endpackage
`default_nettype wire

### rtl/lacb_prescale.sv
`default_nettype none
module lacb_prescale #(
	parameter int IN_W = 33
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [IN_W-1:0] v [3],
	output lacb_pkg::pmag_t             mag [3],
	output logic [2:0]                  neg,
	output logic                        nz
);
	import lacb_pkg::*;

	localparam int LW = $clog2(IN_W + 1);
	localparam int WW = IN_W + PS_BITS;

	logic [IN_W-1:0] m_s1 [3];
	logic [IN_W-1:0] m_s2 [3];
	logic [IN_W-1:0] m_s3 [3];
	logic [2:0]      n_s1, n_s2, n_s3;
	logic [IN_W-1:0] mx_s2;
	logic [LW-1:0]   len_s3;
	logic [IN_W-1:0] mx_d;
	logic [LW-1:0]   len_d;
	logic [WW-1:0]   wide [3];

	always_comb begin
		mx_d = m_s1[0];
		if (m_s1[1] > mx_d) mx_d = m_s1[1];
		if (m_s1[2] > mx_d) mx_d = m_s1[2];
	end

	always_comb begin
		len_d = '0;
		for (int i = 0; i < IN_W; i++)
			if (mx_s2[i]) len_d = LW'(i + 1);
	end

	// (m << PS_BITS) >> len gives exactly PS_BITS bits on the largest
	always_comb begin
		for (int i = 0; i < 3; i++)
			wide[i] = {m_s3[i], {PS_BITS{1'b0}}} >> len_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i] <= v[i][IN_W-1] ? IN_W'(-v[i]) : IN_W'(v[i]);
				n_s1[i] <= v[i][IN_W-1];
				mag[i]  <= wide[i][PS_BITS-1:0];
			end
			m_s2   <= m_s1;
			n_s2   <= n_s1;
			mx_s2  <= mx_d;
			m_s3   <= m_s2;
			n_s3   <= n_s2;
			len_s3 <= len_d;
			neg    <= n_s3;
			nz     <= (len_s3 != '0);
		end
	end
endmodule
`default_nettype wire

### rtl/lacb_norm.sv
`default_nettype none
module lacb_norm (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire lacb_pkg::pmag_t mag [3],
	input  wire logic [2:0]      neg,
	output lacb_pkg::unit_t      q [3]
);
	import lacb_pkg::*;

	localparam int SQ_W = 2 * PS_BITS;
	localparam int S_W  = SQ_W + 2;
	localparam int R_W  = PS_BITS + 1;
	localparam int N_W  = PS_BITS + UNIT_FRAC_BITS + 1;
	localparam int Q_W  = UNIT_FRAC_BITS + 1;

	logic [SQ_W-1:0] sq_s1 [3];
	pmag_t           m_s1 [3];
	logic [2:0]      n_s1;

	// isqrt pipeline, one result bit per stage
	logic [S_W-1:0] rn_s [0:R_W];
	logic [S_W-1:0] rr_s [0:R_W];
	pmag_t          sm_s [0:R_W][3];
	logic [2:0]     sn_s [0:R_W];

	// restoring divider, one quotient bit per stage
	logic [N_W-1:0] dr_s [0:Q_W][3];
	logic [Q_W-1:0] dq_s [0:Q_W][3];
	logic [R_W-1:0] dv_s [0:Q_W];
	logic [2:0]     dn_s [0:Q_W];

	logic [R_W-1:0] r_d;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s1[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
			m_s1    <= mag;
			n_s1    <= neg;
			rn_s[0] <= S_W'(sq_s1[0]) + S_W'(sq_s1[1]) + S_W'(sq_s1[2]);
			rr_s[0] <= '0;
			sm_s[0] <= m_s1;
			sn_s[0] <= n_s1;
		end
	end

	for (genvar k = 0; k < R_W; k++) begin : g_sqrt
		localparam logic [S_W-1:0] BIT = {{(S_W-1){1'b0}}, 1'b1} << (2 * (R_W - 1 - k));
		logic [S_W-1:0] t;
		assign t = rr_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn_s[k] >= t) begin
					rn_s[k+1] <= rn_s[k] - t;
					rr_s[k+1] <= (rr_s[k] >> 1) + BIT;
				end else begin
					rn_s[k+1] <= rn_s[k];
					rr_s[k+1] <= rr_s[k] >> 1;
				end
				sm_s[k+1] <= sm_s[k];
				sn_s[k+1] <= sn_s[k];
			end
		end
	end

	always_comb begin
		r_d = rr_s[R_W][R_W-1:0];
		if (r_d == '0) r_d = {{(R_W-1){1'b0}}, 1'b1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dr_s[0][i] <= (N_W'(sm_s[R_W][i]) << UNIT_FRAC_BITS) + N_W'(r_d >> 1);
				dq_s[0][i] <= '0;
			end
			dv_s[0] <= r_d;
			dn_s[0] <= sn_s[R_W];
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic [N_W-1:0] sh;
		assign sh = N_W'(dv_s[j]) << (Q_W - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dr_s[j][i] >= sh) begin
						dr_s[j+1][i] <= dr_s[j][i] - sh;
						dq_s[j+1][i] <= {dq_s[j][i][Q_W-2:0], 1'b1};
					end else begin
						dr_s[j+1][i] <= dr_s[j][i];
						dq_s[j+1][i] <= {dq_s[j][i][Q_W-2:0], 1'b0};
					end
				end
				dv_s[j+1] <= dv_s[j];
				dn_s[j+1] <= dn_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				q[i] <= dn_s[Q_W][i] ? -UNIT_WIDTH'(dq_s[Q_W][i]) : UNIT_WIDTH'(dq_s[Q_W][i]);
		end
	end
endmodule
`default_nettype wire

### rtl/look_at_camera_basis.sv
// Look-at camera basis, fixed point.
// cmd channel: one beat carries eye, target and up hint (Q16.16). basis
// channel: one beat carries right, true up and forward (Q2.14) and a
// degenerate flag. Both channels use valid/stall; a beat moves on an edge
// with valid high and stall low.
// Throughput: one beat per cycle while cmd_stall is low. The path from a
// cmd beat to basis_valid runs through the chain prescale, cross,
// prescale, cross, prescale and the normalizer, whose 31-stage square
// root and 15-stage divider dominate its depth.
// Stall: basis sits in an output register with one skid entry behind it.
// While the receiver stalls, the pipeline keeps moving until the skid entry
// fills; then the whole pipeline holds and cmd_stall rises.
// Reset clears all valid bits; no beat is in flight after reset.
// A zero-length vector gives zeros for it and for what follows from it,
// with degenerate set.
`default_nettype none
module look_at_camera_basis (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_stall,
	input  wire lacb_pkg::cmd_t   cmd,
	output logic                  basis_valid,
	input  wire logic             basis_stall,
	output lacb_pkg::basis_t      basis
);
	import lacb_pkg::*;
	`include "assert_macros.svh"

	localparam int D_W    = COORD_WIDTH + 1;
	localparam int SG_W   = PS_BITS + 1;
	localparam int PW     = 2 * SG_W;
	localparam int CX_W   = PW + 1;
	localparam int FWX_DL = PS_LAT + 2;
	localparam int RT_DL  = PS_LAT + 2;
	localparam int FW_DL  = 2 * PS_LAT + 4;
	localparam int DEPTH  = 1 + 3 * PS_LAT + 4 + NORM_LAT;

	function automatic logic signed [SG_W-1:0] sgn(pmag_t m, logic n);
		logic signed [SG_W-1:0] x;
		x = $signed({1'b0, m});
		return n ? -x : x;
	endfunction

	logic                    en;
	logic [DEPTH-1:0]        vld_s;
	logic signed [D_W-1:0]   d_s1 [3];
	coord_t                  up_s1 [3];

	pmag_t                   fw_mag [3], up_mag [3], rt_mag [3], tu_mag [3];
	logic [2:0]              fw_neg, up_neg, rt_neg, tu_neg;
	logic                    fw_nz, up_nz, rt_nz, tu_nz;
	logic signed [SG_W-1:0]  fw_sg [3], up_sg [3], rt_sg [3], fwx_sg [3];
	logic signed [SG_W-1:0]  fwd_s [FWX_DL][3];

	logic signed [PW-1:0]    c1p_s6 [6], c2p_s12 [6];
	logic signed [CX_W-1:0]  c1_s7 [3], c2_s13 [3];

	unit_t                   q_fw [3], q_rt [3], q_tu [3];
	unit_t                   qfw_s [FW_DL][3];
	unit_t                   qrt_s [RT_DL][3];
	logic [NORM_LAT-1:0]     nz_s;

	basis_t                  res_d;
	basis_t                  out_q, skid_q;
	logic                    out_v_q, skid_v_q;

	assign en        = !skid_v_q;
	assign cmd_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[DEPTH-2:0], cmd_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0]  <= D_W'(cmd.target_x) - D_W'(cmd.eye_x);
			d_s1[1]  <= D_W'(cmd.target_y) - D_W'(cmd.eye_y);
			d_s1[2]  <= D_W'(cmd.target_z) - D_W'(cmd.eye_z);
			up_s1[0] <= cmd.up_hint_x;
			up_s1[1] <= cmd.up_hint_y;
			up_s1[2] <= cmd.up_hint_z;
		end
	end

	lacb_prescale #(.IN_W(D_W)) u_ps_fw (
		.clk(clk), .en(en), .v(d_s1), .mag(fw_mag), .neg(fw_neg), .nz(fw_nz)
	);
	lacb_prescale #(.IN_W(COORD_WIDTH)) u_ps_up (
		.clk(clk), .en(en), .v(up_s1), .mag(up_mag), .neg(up_neg), .nz(up_nz)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fw_sg[i]  = sgn(fw_mag[i], fw_neg[i]);
			up_sg[i]  = sgn(up_mag[i], up_neg[i]);
			rt_sg[i]  = sgn(rt_mag[i], rt_neg[i]);
			fwx_sg[i] = fwd_s[FWX_DL-1][i];
		end
	end

	// cross(up, forward)
	always_ff @(posedge clk) begin
		if (en) begin
			c1p_s6[0] <= PW'(up_sg[1]) * PW'(fw_sg[2]);
			c1p_s6[1] <= PW'(up_sg[2]) * PW'(fw_sg[1]);
			c1p_s6[2] <= PW'(up_sg[2]) * PW'(fw_sg[0]);
			c1p_s6[3] <= PW'(up_sg[0]) * PW'(fw_sg[2]);
			c1p_s6[4] <= PW'(up_sg[0]) * PW'(fw_sg[1]);
			c1p_s6[5] <= PW'(up_sg[1]) * PW'(fw_sg[0]);
			c1_s7[0]  <= CX_W'(c1p_s6[0]) - CX_W'(c1p_s6[1]);
			c1_s7[1]  <= CX_W'(c1p_s6[2]) - CX_W'(c1p_s6[3]);
			c1_s7[2]  <= CX_W'(c1p_s6[4]) - CX_W'(c1p_s6[5]);
			fwd_s[0]  <= fw_sg;
			for (int k = 1; k < FWX_DL; k++) fwd_s[k] <= fwd_s[k-1];
		end
	end

	lacb_prescale #(.IN_W(CX_W)) u_ps_rt (
		.clk(clk), .en(en), .v(c1_s7), .mag(rt_mag), .neg(rt_neg), .nz(rt_nz)
	);

	// cross(forward, right)
	always_ff @(posedge clk) begin
		if (en) begin
			c2p_s12[0] <= PW'(fwx_sg[1]) * PW'(rt_sg[2]);
			c2p_s12[1] <= PW'(fwx_sg[2]) * PW'(rt_sg[1]);
			c2p_s12[2] <= PW'(fwx_sg[2]) * PW'(rt_sg[0]);
			c2p_s12[3] <= PW'(fwx_sg[0]) * PW'(rt_sg[2]);
			c2p_s12[4] <= PW'(fwx_sg[0]) * PW'(rt_sg[1]);
			c2p_s12[5] <= PW'(fwx_sg[1]) * PW'(rt_sg[0]);
			c2_s13[0]  <= CX_W'(c2p_s12[0]) - CX_W'(c2p_s12[1]);
			c2_s13[1]  <= CX_W'(c2p_s12[2]) - CX_W'(c2p_s12[3]);
			c2_s13[2]  <= CX_W'(c2p_s12[4]) - CX_W'(c2p_s12[5]);
		end
	end

	lacb_prescale #(.IN_W(CX_W)) u_ps_tu (
		.clk(clk), .en(en), .v(c2_s13), .mag(tu_mag), .neg(tu_neg), .nz(tu_nz)
	);

	lacb_norm u_nm_fw (.clk(clk), .en(en), .mag(fw_mag), .neg(fw_neg), .q(q_fw));
	lacb_norm u_nm_rt (.clk(clk), .en(en), .mag(rt_mag), .neg(rt_neg), .q(q_rt));
	lacb_norm u_nm_tu (.clk(clk), .en(en), .mag(tu_mag), .neg(tu_neg), .q(q_tu));

	// a zero forward or zero up hint forces a zero cross, so tu_nz covers all cases
	always_ff @(posedge clk) begin
		if (en) begin
			qfw_s[0] <= q_fw;
			for (int k = 1; k < FW_DL; k++) qfw_s[k] <= qfw_s[k-1];
			qrt_s[0] <= q_rt;
			for (int k = 1; k < RT_DL; k++) qrt_s[k] <= qrt_s[k-1];
			nz_s <= {nz_s[NORM_LAT-2:0], tu_nz & rt_nz & fw_nz & up_nz | tu_nz};
		end
	end

	always_comb begin
		res_d.right_x    = qrt_s[RT_DL-1][0];
		res_d.right_y    = qrt_s[RT_DL-1][1];
		res_d.right_z    = qrt_s[RT_DL-1][2];
		res_d.true_up_x  = q_tu[0];
		res_d.true_up_y  = q_tu[1];
		res_d.true_up_z  = q_tu[2];
		res_d.forward_x  = qfw_s[FW_DL-1][0];
		res_d.forward_y  = qfw_s[FW_DL-1][1];
		res_d.forward_z  = qfw_s[FW_DL-1][2];
		res_d.degenerate = !nz_s[NORM_LAT-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!basis_stall) skid_v_q <= 1'b0;
		end else if (vld_s[DEPTH-1]) begin
			if (!out_v_q || !basis_stall) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (!basis_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!basis_stall) out_q <= skid_q;
		end else if (vld_s[DEPTH-1]) begin
			if (!out_v_q || !basis_stall) out_q <= res_d;
			else skid_q <= res_d;
		end
	end

	assign basis_valid = out_v_q;
	assign basis       = out_q;

	`ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
	`ASSERT_NXT(a_skid_fill, out_v_q && basis_stall && !skid_v_q && vld_s[DEPTH-1], skid_v_q)
	`ASSERT_IMP(a_degen_zero_up, out_v_q && out_q.degenerate, out_q.true_up_x == '0 && out_q.true_up_y == '0 && out_q.true_up_z == '0)
	`ASSERT_IMP(a_nondegen_up, out_v_q && !out_q.degenerate, out_q.true_up_x != '0 || out_q.true_up_y != '0 || out_q.true_up_z != '0)
endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lacb_pkg::*;

	localparam int LATENCY = UNIT_FRAC_BITS + 54;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic basis_valid;
	logic basis_stall = 1'b0;
	basis_t basis;

	basis_t basis_q[$];
	int errors = 0;
	int n_cmd = 0;
	int n_basis = 0;
	int n_degen = 0;
	int idle_cycles = 0;

	look_at_camera_basis uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.basis_valid(basis_valid),
		.basis_stall(basis_stall),
		.basis(basis)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	typedef longint vec3_t [3];

	function automatic longint unsigned abs64(longint x);
		return x < 0 ? -x : x;
	endfunction

	// scale so the largest magnitude has exactly PS_BITS bits; truncating
	function automatic bit scale_vec(input vec3_t v, output vec3_t o);
		longint unsigned m [3];
		longint unsigned mx;
		longint unsigned s;
		int len;
		mx = 0;
		len = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs64(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		for (int i = 0; i < 3; i++)
			o[i] = 0;
		if (mx == 0)
			return 1'b0;
		while (len < 64 && (mx >> len) != 0)
			len++;
		for (int i = 0; i < 3; i++) begin
			s = len > PS_BITS ? m[i] >> (len - PS_BITS) : m[i] << (PS_BITS - len);
			o[i] = v[i] < 0 ? -longint'(s) : longint'(s);
		end
		return 1'b1;
	endfunction

	function automatic vec3_t cross_vec(vec3_t a, vec3_t b);
		vec3_t c;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		return c;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void to_unit(input vec3_t v, output unit_t u [3]);
		longint unsigned m [3];
		longint unsigned s;
		longint unsigned r;
		longint unsigned q;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs64(v[i]);
			s += m[i] * m[i];
		end
		r = int_sqrt(s);
		if (r == 0)
			r = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << UNIT_FRAC_BITS) + (r >> 1)) / r;
			u[i] = unit_t'(v[i] < 0 ? -q : q);
		end
	endfunction

	function automatic basis_t predict_basis(cmd_t c);
		basis_t b;
		vec3_t d, up, fw, upn, rt, tu;
		unit_t u [3];
		b = '0;
		d[0] = longint'(c.target_x) - longint'(c.eye_x);
		d[1] = longint'(c.target_y) - longint'(c.eye_y);
		d[2] = longint'(c.target_z) - longint'(c.eye_z);
		up[0] = c.up_hint_x;
		up[1] = c.up_hint_y;
		up[2] = c.up_hint_z;
		if (!scale_vec(d, fw)) begin
			b.degenerate = 1'b1;
			return b;
		end
		to_unit(fw, u);
		b.forward_x = u[0];
		b.forward_y = u[1];
		b.forward_z = u[2];
		if (!scale_vec(up, upn) || !scale_vec(cross_vec(upn, fw), rt)) begin
			b.degenerate = 1'b1;
			return b;
		end
		to_unit(rt, u);
		b.right_x = u[0];
		b.right_y = u[1];
		b.right_z = u[2];
		if (!scale_vec(cross_vec(fw, rt), tu)) begin
			b.degenerate = 1'b1;
			return b;
		end
		to_unit(tu, u);
		b.true_up_x = u[0];
		b.true_up_y = u[1];
		b.true_up_z = u[2];
		return b;
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// receiver: stalls on its own pattern, sometimes long, sometimes none
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(negedge clk);
				case (mode)
					0: basis_stall <= 1'b0;
					1: basis_stall <= ($urandom_range(0, 3) == 0);
					2: basis_stall <= ($urandom_range(0, 1) == 0);
					default: basis_stall <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		basis_t exp_b;
		if (arst_n && basis_valid && !basis_stall) begin
			n_basis++;
			if (basis_q.size() == 0) begin
				$error("basis beat with no expectation pending");
				errors++;
			end else begin
				exp_b = basis_q.pop_front();
				if (exp_b.degenerate)
					n_degen++;
				check_field("right_x", exp_b.right_x, basis.right_x);
				check_field("right_y", exp_b.right_y, basis.right_y);
				check_field("right_z", exp_b.right_z, basis.right_z);
				check_field("true_up_x", exp_b.true_up_x, basis.true_up_x);
				check_field("true_up_y", exp_b.true_up_y, basis.true_up_y);
				check_field("true_up_z", exp_b.true_up_z, basis.true_up_z);
				check_field("forward_x", exp_b.forward_x, basis.forward_x);
				check_field("forward_y", exp_b.forward_y, basis.forward_y);
				check_field("forward_z", exp_b.forward_z, basis.forward_z);
				check_field("degenerate", exp_b.degenerate, basis.degenerate);
			end
		end
		if (arst_n && cmd_valid && !cmd_stall) begin
			n_cmd++;
			basis_q.push_back(predict_basis(cmd));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (basis_valid && !basis_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 200)) - 100);
			2: return coord_t'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
			3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return coord_t'($signed($urandom_range(0, 32'hFFF_FFFF)) - 32'sh800_0000);
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.eye_x = rand_coord();
		c.eye_y = rand_coord();
		c.eye_z = rand_coord();
		c.target_x = rand_coord();
		c.target_y = rand_coord();
		c.target_z = rand_coord();
		c.up_hint_x = rand_coord();
		c.up_hint_y = rand_coord();
		c.up_hint_z = rand_coord();
		case ($urandom_range(0, 19))
			0: {c.target_x, c.target_y, c.target_z} = {c.eye_x, c.eye_y, c.eye_z};
			1: {c.up_hint_x, c.up_hint_y, c.up_hint_z} = '0;
			2: begin
				// up hint parallel to forward
				c.eye_x = rand_coord() >>> 2;
				c.eye_y = rand_coord() >>> 2;
				c.eye_z = rand_coord() >>> 2;
				c.target_x = c.eye_x + 32'sd3;
				c.target_y = c.eye_y - 32'sd5;
				c.target_z = c.eye_z + 32'sd7;
				c.up_hint_x = -32'sd6;
				c.up_hint_y = 32'sd10;
				c.up_hint_z = -32'sd14;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic send_cmd(cmd_t c);
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	typedef struct {
		cmd_t c;
		bit has_exp;
		basis_t b;
	} row_t;

	localparam coord_t MAXC = 32'sh7FFF_FFFF;
	localparam coord_t MINC = 32'sh8000_0000;
	localparam coord_t ONE = 32'sh0001_0000;
	localparam unit_t U1 = unit_t'(1 << UNIT_FRAC_BITS);

	row_t rows[$];

	initial begin
		int left;
		rows = '{
			'{'{0, 0, 0, 0, 0, 0, 0, ONE, 0}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1}},
			'{'{MAXC, MINC, 5, MAXC, MINC, 5, 0, ONE, 0}, 1,
				'{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1}},
			'{'{0, 0, 0, 0, 0, ONE, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, U1, 1'b1}},
			'{'{0, 0, 0, 0, 0, ONE, 0, 0, 3 * ONE}, 1,
				'{0, 0, 0, 0, 0, 0, 0, 0, U1, 1'b1}},
			'{'{0, 0, 0, 0, 0, ONE, 0, ONE, 0}, 1, '{U1, 0, 0, 0, U1, 0, 0, 0, U1, 1'b0}},
			'{'{0, 0, 0, ONE, 0, 0, 0, 0, ONE}, 1, '{0, U1, 0, 0, 0, U1, U1, 0, 0, 1'b0}},
			'{'{MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC}, 0, '0},
			'{'{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC}, 0, '0},
			'{'{MAXC, 0, MINC, MINC, 1, MAXC, 1, 1, 1}, 0, '0},
			'{'{0, 0, 0, 1, 0, 0, MINC, MINC, MINC}, 0, '0},
			'{'{0, 0, 0, 1, 1, 1, MAXC, MAXC, MAXC}, 0, '0},
			'{'{-1, -1, -1, -1, -1, 0, -1, -1, -1}, 0, '0},
			'{'{0, 0, 0, MINC, 0, 0, 0, MAXC, 0}, 1,
				'{0, 0, U1, 0, U1, 0, -U1, 0, 0, 1'b0}},
			'{'{ONE, 2 * ONE, 3 * ONE, -ONE, 5 * ONE, 7, 11, -13, 17}, 0, '0},
			'{'{32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 32'h5555_5555, 32'shAAAA_AAAA,
				-1, 1, -1}, 0, '0}
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send_cmd(rows[i].c);
			if (rows[i].has_exp)
				basis_q[$] = rows[i].b;
			if ($urandom_range(0, 1) == 0) begin
				cmd_valid <= 1'b0;
				@(negedge clk);
			end
		end
		cmd_valid <= 1'b0;

		// drain fully before random traffic
		while (basis_q.size() != 0)
			@(negedge clk);

		left = N_RANDOM;
		while (left > 0) begin
			int burst;
			burst = $urandom_range(1, 40);
			if (burst > left)
				burst = left;
			repeat (burst) begin
				send_cmd(rand_cmd());
				left--;
			end
			cmd_valid <= 1'b0;
			if ($urandom_range(0, 29) == 0) begin
				while (basis_q.size() != 0)
					@(negedge clk);
			end else begin
				repeat ($urandom_range(1, 12))
					@(negedge clk);
			end
		end
		cmd_valid <= 1'b0;

		while (basis_q.size() != 0)
			@(negedge clk);
		repeat (2 * LATENCY)
			@(negedge clk);
		$display("Applied %0d look-at commands, checked %0d basis beats (%0d degenerate).",
			n_cmd, n_basis, n_degen);
		if (errors == 0 && basis_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
